FILE: sv/oss_pkg.sv
package oss_pkg;

	localparam int CAPACITY_DEF = 1024;

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_DELETE = 2'd1;
	localparam logic [1:0] OP_QUERY  = 2'd2;

	localparam logic [1:0] ST_DONE    = 2'd0;
	localparam logic [1:0] ST_IGNORED = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;
	localparam logic [1:0] ST_RANGE   = 2'd3;

	// read address sources of the store
	localparam logic [1:0] RD_MID   = 2'd0;
	localparam logic [1:0] RD_POS   = 2'd1;
	localparam logic [1:0] RD_RANK  = 2'd2;
	localparam logic [1:0] RD_SHIFT = 2'd3;

	typedef struct packed {
		logic       start;
		logic       rd_en;
		logic [1:0] rd_sel;
		logic       srch_upd;
		logic       shift_ins;
		logic       shift_del;
		logic       shift_step;
		logic       wr_final;
		logic       cnt_inc;
		logic       cnt_dec;
		logic       res_load;
		logic       out_load;
		logic [1:0] out_status;
	} cmd_t;

	typedef struct packed {
		logic srch_done;
		logic pos_lt_cnt;
		logic found;
		logic full;
		logic rank_bad;
		logic shift_more;
		logic out_free;
	} sts_t;

endpackage

FILE: sv/oss_ctrl.sv
module oss_ctrl
	import oss_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [1:0] op,
	input  sts_t       sts,
	output cmd_t       cmd,
	output logic       in_stall
);

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_SRCH_RD  = 4'd1;
	localparam logic [3:0] S_SRCH_CMP = 4'd2;
	localparam logic [3:0] S_FIND_RD  = 4'd3;
	localparam logic [3:0] S_FIND_CMP = 4'd4;
	localparam logic [3:0] S_SHIFT    = 4'd5;
	localparam logic [3:0] S_DRAIN    = 4'd6;
	localparam logic [3:0] S_FINAL    = 4'd7;
	localparam logic [3:0] S_Q_RD     = 4'd8;
	localparam logic [3:0] S_Q_LOAD   = 4'd9;
	localparam logic [3:0] S_DONE     = 4'd10;

	logic [3:0] state_q, state_d;
	logic [1:0] op_q, op_d;
	logic [1:0] st_q, st_d;

	assign in_stall = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q    <= OP_INSERT;
			st_q    <= ST_DONE;
		end else begin
			state_q <= state_d;
			op_q    <= op_d;
			st_q    <= st_d;
		end
	end

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		op_d    = op_q;
		st_d    = st_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.start = 1'b1;
					op_d      = op;
					if (op == OP_INSERT || op == OP_DELETE) begin
						state_d = S_SRCH_RD;
					end else if (op == OP_QUERY) begin
						state_d = S_Q_RD;
					end else begin
						st_d    = ST_IGNORED;
						state_d = S_DONE;
					end
				end
			end
			S_SRCH_RD: begin
				if (sts.srch_done) begin
					state_d = S_FIND_RD;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_MID;
					state_d    = S_SRCH_CMP;
				end
			end
			S_SRCH_CMP: begin
				cmd.srch_upd = 1'b1;
				state_d      = S_SRCH_RD;
			end
			S_FIND_RD: begin
				cmd.rd_en  = sts.pos_lt_cnt;
				cmd.rd_sel = RD_POS;
				state_d    = S_FIND_CMP;
			end
			S_FIND_CMP: begin
				if (op_q == OP_INSERT) begin
					if (sts.found) begin
						st_d    = ST_IGNORED;
						state_d = S_DONE;
					end else if (sts.full) begin
						st_d    = ST_FULL;
						state_d = S_DONE;
					end else begin
						cmd.shift_ins = 1'b1;
						state_d       = S_SHIFT;
					end
				end else begin
					if (sts.found) begin
						cmd.shift_del = 1'b1;
						state_d       = S_SHIFT;
					end else begin
						st_d    = ST_IGNORED;
						state_d = S_DONE;
					end
				end
			end
			S_SHIFT: begin
				if (sts.shift_more) begin
					cmd.shift_step = 1'b1;
					cmd.rd_en      = 1'b1;
					cmd.rd_sel     = RD_SHIFT;
				end else begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				// the last moved entry has been written back on entering this state
				st_d = ST_DONE;
				if (op_q == OP_INSERT) begin
					state_d = S_FINAL;
				end else begin
					cmd.cnt_dec = 1'b1;
					state_d     = S_DONE;
				end
			end
			S_FINAL: begin
				cmd.wr_final = 1'b1;
				cmd.cnt_inc  = 1'b1;
				state_d      = S_DONE;
			end
			S_Q_RD: begin
				if (sts.rank_bad) begin
					st_d    = ST_RANGE;
					state_d = S_DONE;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_RANK;
					state_d    = S_Q_LOAD;
				end
			end
			S_Q_LOAD: begin
				cmd.res_load = 1'b1;
				st_d         = ST_DONE;
				state_d      = S_DONE;
			end
			S_DONE: begin
				// hold until the output slot is free
				if (sts.out_free) begin
					cmd.out_load   = 1'b1;
					cmd.out_status = st_q;
					state_d        = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

FILE: sv/oss_dp.sv
module oss_dp
	import oss_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  cmd_t                               cmd,
	output sts_t                               sts,
	input  logic signed [31:0]                 value,
	input  logic [15:0]                        rank,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [31:0]                 result_value,
	output logic [1:0]                         status,
	output logic [$clog2(CAPACITY+1)-1:0]      count
);

	localparam int AW    = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = (CNT_W > 16) ? CNT_W : 16;

	logic signed [31:0] mem [CAPACITY];

	logic signed [31:0] val_q;
	logic [15:0]        rank_q;
	logic [CNT_W-1:0]   lo_q, hi_q, dest_q, cnt_q;
	logic               dir_q;
	logic               pend_s1;
	logic [AW-1:0]      wa_s1;
	logic signed [31:0] rdata_q;
	logic signed [31:0] res_q;
	logic               out_valid_q;
	logic signed [31:0] out_value_q;
	logic [1:0]         out_status_q;
	logic [CNT_W-1:0]   out_count_q;

	logic [CNT_W-1:0] mid;
	logic [CNT_W-1:0] dest_up, dest_dn, sh_src;
	logic [CMP_W-1:0] rank_w, cnt_w, rank_m1;
	logic [AW-1:0]    raddr;

	assign mid     = lo_q + ((hi_q - lo_q) >> 1);
	assign dest_up = dest_q + 1'b1;
	assign dest_dn = dest_q - 1'b1;
	assign sh_src  = dir_q ? dest_up : dest_dn;
	assign rank_w  = CMP_W'(rank_q);
	assign cnt_w   = CMP_W'(cnt_q);
	assign rank_m1 = rank_w - 1'b1;

	always_comb begin
		unique case (cmd.rd_sel)
			RD_MID:   raddr = mid[AW-1:0];
			RD_POS:   raddr = lo_q[AW-1:0];
			RD_RANK:  raddr = rank_m1[AW-1:0];
			RD_SHIFT: raddr = sh_src[AW-1:0];
			default:  raddr = mid[AW-1:0];
		endcase
	end

	assign sts.srch_done  = (lo_q >= hi_q);
	assign sts.pos_lt_cnt = (lo_q < cnt_q);
	assign sts.found      = (lo_q < cnt_q) && (rdata_q == val_q);
	assign sts.full       = (cnt_q >= CNT_W'(CAPACITY));
	assign sts.rank_bad   = (rank_q == '0) || (rank_w > cnt_w);
	assign sts.shift_more = dir_q ? (dest_up < cnt_q) : (dest_q > lo_q);
	assign sts.out_free   = !out_valid_q || !out_stall;

	// store: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (pend_s1) begin
			mem[wa_s1] <= rdata_q;
		end else if (cmd.wr_final) begin
			mem[lo_q[AW-1:0]] <= val_q;
		end
		if (cmd.rd_en) begin
			rdata_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			pend_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			pend_s1 <= cmd.shift_step;
			if (cmd.cnt_inc) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (cmd.cnt_dec) begin
				cnt_q <= cnt_q - 1'b1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			val_q  <= value;
			rank_q <= rank;
			lo_q   <= '0;
			hi_q   <= cnt_q;
			res_q  <= '0;
		end
		if (cmd.srch_upd) begin
			if (rdata_q < val_q) begin
				lo_q <= mid + 1'b1;
			end else begin
				hi_q <= mid;
			end
		end
		if (cmd.shift_ins) begin
			dir_q  <= 1'b0;
			dest_q <= cnt_q;
		end else if (cmd.shift_del) begin
			dir_q  <= 1'b1;
			dest_q <= lo_q;
		end else if (cmd.shift_step) begin
			dest_q <= sh_src;
		end
		if (cmd.shift_step) begin
			wa_s1 <= dest_q[AW-1:0];
		end
		if (cmd.res_load) begin
			res_q <= rdata_q;
		end
		if (cmd.out_load) begin
			out_value_q  <= res_q;
			out_status_q <= cmd.out_status;
			out_count_q  <= cnt_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign result_value = out_value_q;
	assign status       = out_status_q;
	assign count        = out_count_q;

endmodule

FILE: sv/order_statistic_set.sv
// Sorted set of distinct signed 32-bit values with insert, delete and
// k-th smallest query.
// Input channel: in_valid / in_stall with op, value, rank. A transaction
// is taken when in_valid is high and in_stall low; in_stall stays high
// while a request is in progress, so one request is handled at a time.
// Output channel: out_valid / out_stall with result_value, status, count;
// every request gives exactly one result, held in an output register.
// A query reads the entry at its rank and loads it as the result; a rank
// out of range and an unused op finish without a read. Insert and delete
// run a binary search over the sorted store, read and check the entry at
// the found position, then move the larger entries one slot per cycle
// through the single write port (count - pos for insert, count - pos - 1 for
// delete); insert then writes the new value and counts it in, delete counts
// the removed value out. A duplicate, a full set or an absent value finishes
// after the check, with no move. The next request is taken once the result
// is loaded. The store's one read and one write port per cycle set the pace.
// If the receiver stalls, the finished result waits in the output register
// and the next request waits in its final state until the slot is free.
// Reset clears the element count and the output valid; the store contents
// are never read above the count, so it needs no clearing.
module order_statistic_set
	import oss_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    op,
	input  logic signed [31:0]            value,
	input  logic [15:0]                   rank,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [31:0]            result_value,
	output logic [1:0]                    status,
	output logic [$clog2(CAPACITY+1)-1:0] count
);

	cmd_t cmd;
	sts_t sts;

	oss_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.op       (op),
		.sts      (sts),
		.cmd      (cmd),
		.in_stall (in_stall)
	);

	oss_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.value        (value),
		.rank         (rank),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.result_value (result_value),
		.status       (status),
		.count        (count)
	);

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top
	import oss_pkg::*;
;

	localparam int CNT_W = $clog2(CAPACITY_DEF + 1);
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;
	localparam int HOLD_AT = 300;
	localparam int HOLD_LEN = 400;
	localparam int RANDOM_END = 820;
	localparam int POOL_N = 24;

	typedef struct {
		logic signed [31:0] value;
		logic [1:0]         status;
		logic [CNT_W-1:0]   count;
	} set_result_t;

	class ordered_set_scoreboard;
		logic signed [31:0] held_values[$];
		set_result_t        awaited_results[$];
		int                 mismatches;

		function new();
			mismatches = 0;
		endfunction

		// Mirror one accepted request on the sorted set and queue its result.
		function void apply_request(logic [1:0] req_op, logic signed [31:0] req_value,
				logic [15:0] req_rank);
			set_result_t r;
			int pos;
			bit found;
			r.value = '0;
			r.status = ST_IGNORED;
			unique case (req_op)
				OP_INSERT, OP_DELETE: begin
					pos = 0;
					while (pos < held_values.size() && held_values[pos] < req_value)
						pos++;
					found = pos < held_values.size() && held_values[pos] == req_value;
					if (req_op == OP_INSERT) begin
						if (found)
							r.status = ST_IGNORED;
						else if (held_values.size() >= CAPACITY_DEF)
							r.status = ST_FULL;
						else begin
							held_values.insert(pos, req_value);
							r.status = ST_DONE;
						end
					end else if (found) begin
						held_values.delete(pos);
						r.status = ST_DONE;
					end
				end
				OP_QUERY: begin
					if (req_rank == 0 || req_rank > held_values.size())
						r.status = ST_RANGE;
					else begin
						r.value = held_values[req_rank - 1];
						r.status = ST_DONE;
					end
				end
				default: ;
			endcase
			r.count = CNT_W'(held_values.size());
			awaited_results.push_back(r);
		endfunction

		function void check_result(logic signed [31:0] got_value, logic [1:0] got_status,
				logic [CNT_W-1:0] got_count);
			set_result_t want;
			if (awaited_results.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result: value %0d status %0d count %0d",
					$time, got_value, got_status, got_count);
				return;
			end
			want = awaited_results.pop_front();
			if (got_value !== want.value) begin
				mismatches++;
				$display("%0t: result_value expected %0d actual %0d",
					$time, want.value, got_value);
			end
			if (got_status !== want.status) begin
				mismatches++;
				$display("%0t: status expected %0d actual %0d", $time, want.status, got_status);
			end
			if (got_count !== want.count) begin
				mismatches++;
				$display("%0t: count expected %0d actual %0d", $time, want.count, got_count);
			end
		endfunction
	endclass

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     in_stall;
	logic [1:0]               op = OP_INSERT;
	logic signed [31:0]       value = '0;
	logic [15:0]              rank = '0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic signed [31:0]       result_value;
	logic [1:0]               status;
	logic [CNT_W-1:0]         count;

	ordered_set_scoreboard board = new();
	int sent_count = 0;
	int send_idle_pct = 9;
	int recv_idle_pct = 65;

	order_statistic_set dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.op(op),
		.value(value),
		.rank(rank),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.result_value(result_value),
		.status(status),
		.count(count)
	);

	always #4 clk = ~clk;

	initial begin
		#20_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	task automatic send_request(input logic [1:0] req_op, input logic signed [31:0] req_value,
			input logic [15:0] req_rank);
		if (sent_count < 630) begin
			send_idle_pct = 9;
			recv_idle_pct = 65;
		end else if (sent_count < 1260) begin
			send_idle_pct = 65;
			recv_idle_pct = 9;
		end else begin
			send_idle_pct = 0;
			recv_idle_pct = 0;
		end
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		op <= req_op;
		value <= req_value;
		rank <= req_rank;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		board.apply_request(req_op, req_value, req_rank);
		sent_count++;
	endtask

	// Result side: check each transaction, stall at random, and once hold off
	// long enough for the block to back up into its input.
	initial begin
		int hold_left;
		bit hold_done;
		hold_left = 0;
		hold_done = 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall)
				board.check_result(result_value, status, count);
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (!hold_done && sent_count >= HOLD_AT) begin
				hold_done = 1'b1;
				hold_left = HOLD_LEN - 1;
				out_stall <= 1'b1;
			end else
				out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
		end
	end

	initial begin
		logic signed [31:0] pool[POOL_N];
		logic signed [31:0] drain[$];
		logic signed [31:0] r_value;
		logic signed [31:0] fill_value;
		logic signed [31:0] victim;
		logic [1:0]         r_op;
		logic [15:0]        r_rank;
		int                 n;
		int                 pick;
		int                 k;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty set, extremes, duplicates, absent deletes, bad ranks, unused op
		send_request(OP_QUERY, 0, 1);
		send_request(OP_DELETE, 5, 0);
		send_request(OP_INSERT, VAL_MIN, 16'hffff);
		send_request(OP_INSERT, VAL_MAX, 0);
		send_request(OP_INSERT, 0, 16'h5a5a);
		send_request(OP_INSERT, -1, 1);
		send_request(OP_INSERT, VAL_MAX, 2);
		send_request(OP_QUERY, VAL_MAX, 0);
		send_request(OP_QUERY, -1, 1);
		send_request(OP_QUERY, 0, 4);
		send_request(OP_QUERY, 0, 5);
		send_request(OP_QUERY, 0, 16'hffff);
		send_request(OP_UNUSED, VAL_MAX, 16'hffff);
		send_request(OP_DELETE, 0, 3);
		send_request(OP_DELETE, 0, 3);
		send_request(OP_QUERY, 0, 2);
		send_request(OP_DELETE, VAL_MIN, 0);
		send_request(OP_DELETE, VAL_MAX, 0);
		send_request(OP_DELETE, -1, 16'hffff);
		send_request(OP_QUERY, 0, 1);

		// random traffic over a small pool so that hits and misses both occur
		n = 0;
		while (sent_count < RANDOM_END) begin
			if (n % 200 == 0) begin
				pool[0] = VAL_MIN;
				pool[1] = VAL_MAX;
				for (int i = 2; i < POOL_N; i++)
					pool[i] = (i < 8) ? $signed($urandom_range(0, 15)) - 8 : $urandom;
			end
			n++;
			pick = $urandom_range(0, 99);
			if (pick < 40)
				r_op = OP_INSERT;
			else if (pick < 70)
				r_op = OP_DELETE;
			else if (pick < 95)
				r_op = OP_QUERY;
			else
				r_op = OP_UNUSED;
			r_value = ($urandom_range(0, 9) == 0) ? $urandom : pool[$urandom_range(0, POOL_N - 1)];
			if (r_op == OP_QUERY && $urandom_range(0, 4) != 0)
				r_rank = 16'($urandom_range(0, board.held_values.size() + 1));
			else
				r_rank = 16'($urandom_range(0, 65535));
			send_request(r_op, r_value, r_rank);
		end

		// empty the set from the top down, which needs no shifting
		drain = board.held_values;
		for (int i = drain.size() - 1; i >= 0; i--)
			send_request(OP_DELETE, drain[i], 16'($urandom_range(0, 65535)));

		// fill to capacity in ascending order
		fill_value = VAL_MIN + $urandom_range(1, 1000);
		for (int i = 0; i < CAPACITY_DEF; i++) begin
			send_request(OP_INSERT, fill_value, 16'($urandom_range(0, 65535)));
			if (i < CAPACITY_DEF - 1)
				fill_value += $urandom_range(1, 2000000);
		end

		send_request(OP_INSERT, fill_value, 0);
		send_request(OP_INSERT, fill_value + 1, 0);
		send_request(OP_INSERT, VAL_MIN, 0);
		send_request(OP_QUERY, 0, 16'(CAPACITY_DEF));
		send_request(OP_QUERY, 0, 16'(CAPACITY_DEF + 1));
		send_request(OP_QUERY, 0, 0);
		send_request(OP_QUERY, 0, 1);
		send_request(OP_DELETE, VAL_MAX, 0);

		// punch holes in the middle of a full set and refill them
		repeat (12) begin
			k = $urandom_range(1, CAPACITY_DEF);
			victim = board.held_values[k - 1];
			send_request(OP_DELETE, victim, 16'($urandom_range(0, 65535)));
			send_request(OP_QUERY, $urandom, 16'(k));
			send_request(OP_INSERT, victim, 16'($urandom_range(0, 65535)));
			send_request(OP_INSERT, $urandom, 16'($urandom_range(0, 65535)));
		end

		in_valid <= 1'b0;
		while (board.awaited_results.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		if (board.mismatches == 0 && board.awaited_results.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

FILE: order_statistic_set.f
sv/oss_pkg.sv
sv/oss_ctrl.sv
sv/oss_dp.sv
sv/order_statistic_set.sv
verif/tb_top.sv
